FILE: sv/bracketed_command_framer_defines.svh
// Assertion macros used by the framer top level.
`ifndef BRACKETED_COMMAND_FRAMER_DEFINES_SVH
`define BRACKETED_COMMAND_FRAMER_DEFINES_SVH

// Whenever ante holds, cons must hold in the same cycle.
`define BCF_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// cond must never hold.
`define BCF_ASSERT_NEVER(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error(msg);

`endif

FILE: sv/bcf_pkg.sv
// Types and constants of the bracketed command framer.
`timescale 1ns / 1ps

package bcf_pkg;

   localparam int LEN_W = 5;

   localparam logic [7:0] CH_OPEN  = 8'h3C;  // '<'
   localparam logic [7:0] CH_CLOSE = 8'h3E;  // '>'
   localparam logic [7:0] CH_F     = 8'h46;  // 'F'
   localparam logic [7:0] CH_R     = 8'h52;  // 'R'
   localparam logic [7:0] CH_ONE   = 8'h31;  // '1'
   localparam logic [7:0] CH_H     = 8'h48;  // 'H'

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_TYPE,
      ST_DEV,
      ST_BODY,
      ST_READ,
      ST_SEND,
      ST_FIN
   } bcf_state_type;

   typedef enum logic [1:0] {
      EV_UNKNOWN = 2'd0,
      EV_TOOLONG = 2'd1,
      EV_BYTE    = 2'd2,
      EV_END     = 2'd3
   } bcf_event_type;

   typedef struct packed {
      logic byte_open;
      logic byte_close;
      logic byte_type_ok;
      logic byte_dev_ok;
      logic body_full;
      logic body_empty;
      logic idx_last;
      logic out_free;
   } bcf_status_type;

   typedef struct packed {
      logic          set_type;
      logic          set_dev;
      logic          clear_count;
      logic          store_byte;
      logic          clear_idx;
      logic          inc_idx;
      logic          load_out;
      bcf_event_type out_event;
   } bcf_cmd_type;

   typedef struct packed {
      logic [1:0]       event_res;
      logic             device_type;
      logic             device_select;
      logic [7:0]       body_byte;
      logic [LEN_W-1:0] body_length;
      logic             last;
   } bcf_rsp_type;

endpackage

FILE: sv/bcf_req_if.sv
// Input byte channel.
`timescale 1ns / 1ps

interface bcf_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

FILE: sv/bcf_rsp_if.sv
// Result channel.
`timescale 1ns / 1ps

interface bcf_rsp_if import bcf_pkg::*; ;
   logic             valid;
   logic             ready;
   logic [1:0]       event_res;
   logic             device_type;
   logic             device_select;
   logic [7:0]       body_byte;
   logic [LEN_W-1:0] body_length;
   logic             last;

   modport source (output valid, output event_res, output device_type,
                   output device_select, output body_byte, output body_length,
                   output last, input ready);
   modport sink   (input valid, input event_res, input device_type,
                   input device_select, input body_byte, input body_length,
                   input last, output ready);
endinterface

FILE: sv/bcf_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module bcf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                   clock,
   input  logic                                   we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                       wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                       rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

FILE: sv/bcf_ctrl.sv
// Framer controller: frame parsing and body playback sequencing.
`timescale 1ns / 1ps

module bcf_ctrl import bcf_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   input  bcf_status_type status,
   output bcf_cmd_type    cmd
);

   bcf_state_type state_ff;
   bcf_state_type state_in;
   logic          accept;

   // Input is taken only in parsing states and only when a result can land.
   always_comb begin
      unique case (state_ff) inside
         ST_IDLE, ST_TYPE, ST_DEV, ST_BODY: req_ready = status.out_free;
         default:                           req_ready = 1'b0;
      endcase
   end

   assign accept = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept && status.byte_open) state_in = ST_TYPE;
         end
         ST_TYPE: begin
            if (accept) state_in = status.byte_type_ok ? ST_DEV : ST_IDLE;
         end
         ST_DEV: begin
            if (accept) state_in = status.byte_dev_ok ? ST_BODY : ST_IDLE;
         end
         ST_BODY: begin
            if (accept) begin
               if (status.body_full) begin
                  state_in = ST_IDLE;
               end else if (status.byte_close) begin
                  state_in = status.body_empty ? ST_IDLE : ST_READ;
               end else if (status.byte_open) begin
                  state_in = ST_TYPE;
               end
            end
         end
         ST_READ: state_in = ST_SEND;
         ST_SEND: begin
            if (status.out_free) state_in = status.idx_last ? ST_FIN : ST_READ;
         end
         ST_FIN: begin
            if (status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Datapath commands
   always_comb begin
      cmd = '0;
      cmd.out_event = EV_UNKNOWN;
      unique case (state_ff)
         ST_IDLE: ;
         ST_TYPE: begin
            if (accept) begin
               cmd.set_type = status.byte_type_ok;
               cmd.load_out = !status.byte_type_ok;
            end
         end
         ST_DEV: begin
            if (accept) begin
               cmd.set_dev     = status.byte_dev_ok;
               cmd.clear_count = status.byte_dev_ok;
               cmd.load_out    = !status.byte_dev_ok;
            end
         end
         ST_BODY: begin
            if (accept) begin
               if (status.body_full) begin
                  cmd.load_out  = 1'b1;
                  cmd.out_event = EV_TOOLONG;
               end else if (status.byte_close) begin
                  cmd.load_out  = status.body_empty;
                  cmd.out_event = EV_END;
                  cmd.clear_idx = 1'b1;
               end else if (!status.byte_open) begin
                  cmd.store_byte = 1'b1;
               end
            end
         end
         ST_READ: ;
         ST_SEND: begin
            cmd.out_event = EV_BYTE;
            if (status.out_free) begin
               cmd.load_out = 1'b1;
               cmd.inc_idx  = !status.idx_last;
            end
         end
         ST_FIN: begin
            cmd.out_event = EV_END;
            cmd.load_out  = status.out_free;
         end
         default: ;
      endcase
   end

endmodule

FILE: sv/bcf_dp.sv
// Framer datapath: byte decode, flags, body store and result register.
`timescale 1ns / 1ps

module bcf_dp import bcf_pkg::*; #(
   parameter int MAX_BODY = 16
) (
   input  logic           clock,
   input  logic           reset,
   input  logic [7:0]     rx_byte,
   input  bcf_cmd_type    cmd,
   output bcf_status_type status,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output bcf_rsp_type    rsp_data
);

   localparam int CW = $clog2(MAX_BODY + 1);
   localparam int AW = (MAX_BODY > 1) ? $clog2(MAX_BODY) : 1;

   logic          type_ff, type_in;
   logic          dev_ff, dev_in;
   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic          valid_ff, valid_in;
   bcf_rsp_type   data_ff, data_in;
   logic [7:0]    ram_rdata;
   logic [CW+LEN_W-1:0] len_ext;

   bcf_ram #(
      .WIDTH (8),
      .DEPTH (MAX_BODY)
   ) u_body_ram (
      .clock (clock),
      .we    (cmd.store_byte),
      .waddr (count_ff[AW-1:0]),
      .wdata (rx_byte),
      .raddr (idx_ff),
      .rdata (ram_rdata)
   );

   assign status.byte_open    = (rx_byte == CH_OPEN);
   assign status.byte_close   = (rx_byte == CH_CLOSE);
   assign status.byte_type_ok = (rx_byte == CH_F) || (rx_byte == CH_R);
   assign status.byte_dev_ok  = (rx_byte == CH_ONE) || (rx_byte == CH_H);
   assign status.body_full    = (count_ff == CW'(MAX_BODY));
   assign status.body_empty   = (count_ff == '0);
   assign status.idx_last     = ((CW'(idx_ff) + CW'(1)) == count_ff);
   assign status.out_free     = !valid_ff || rsp_ready;

   // length field keeps the low bits of the count
   assign len_ext = {{LEN_W{1'b0}}, count_ff};

   always_comb begin
      type_in  = cmd.set_type ? (rx_byte == CH_R) : type_ff;
      dev_in   = cmd.set_dev ? (rx_byte == CH_H) : dev_ff;
      count_in = count_ff;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.store_byte) begin
         count_in = count_ff + CW'(1);
      end
      idx_in = idx_ff;
      if (cmd.clear_idx) begin
         idx_in = '0;
      end else if (cmd.inc_idx) begin
         idx_in = idx_ff + AW'(1);
      end
      valid_in = cmd.load_out ? 1'b1 : (rsp_ready ? 1'b0 : valid_ff);

      data_in               = data_ff;
      if (cmd.load_out) begin
         data_in.event_res     = cmd.out_event;
         data_in.device_type   = type_ff;
         data_in.device_select = dev_ff;
         data_in.body_byte     = '0;
         data_in.body_length   = '0;
         data_in.last          = 1'b1;
         case (cmd.out_event)
            EV_UNKNOWN: begin
               data_in.device_type   = 1'b0;
               data_in.device_select = 1'b0;
            end
            EV_BYTE: begin
               data_in.body_byte = ram_rdata;
               data_in.last      = 1'b0;
            end
            EV_END:  data_in.body_length = len_ext[LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         type_ff  <= 1'b0;
         dev_ff   <= 1'b0;
         count_ff <= '0;
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         type_ff  <= type_in;
         dev_ff   <= dev_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

endmodule

FILE: sv/bracketed_command_framer.sv
// Bracketed command framer: top level.
//
// Usage:
//  req_bus carries one received text byte (rx_byte) per beat. Frames look like
//  '<' type('F'|'R') device('1'|'H') body... '>'. Bytes outside a frame drop.
//  rsp_bus carries results: unknown-command error, too-long error, one beat
//  per body byte, then a frame-end beat carrying the body length.
//  'last' marks the final result beat caused by one input beat.
// Timing:
//  Any single result that a parsing byte causes is in the output register on the
//  next cycle. On '>' the input stalls while the body plays back from the body
//  RAM: each body byte passes a RAM read state, then an output load state that
//  waits for a free output register, and a final state loads the frame end.
//  The RAM's registered read port is why each byte needs its own read state.
// Stall:
//  One output register sits between the sides; a new byte is taken while
//  rsp is stalled only if that register will be free. Stalled beats hold.
// Reset:
//  Synchronous, active high; returns to idle, clears flags, count and the
//  output valid. Body RAM contents are not cleared (only written bytes read).
`timescale 1ns / 1ps
`include "bracketed_command_framer_defines.svh"

module bracketed_command_framer import bcf_pkg::*; #(
   parameter int MAX_BODY = 16
) (
   input  logic     clock,
   input  logic     reset,
   bcf_req_if.sink  req_bus,
   bcf_rsp_if.source rsp_bus
);

   bcf_status_type status;
   bcf_cmd_type    cmd;
   bcf_rsp_type    rsp_data;

   // parse / playback sequencer
   bcf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // flags, body store, output register
   bcf_dp #(
      .MAX_BODY (MAX_BODY)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .rx_byte   (req_bus.rx_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .rsp_data  (rsp_data)
   );

   assign rsp_bus.event_res     = rsp_data.event_res;
   assign rsp_bus.device_type   = rsp_data.device_type;
   assign rsp_bus.device_select = rsp_data.device_select;
   assign rsp_bus.body_byte     = rsp_data.body_byte;
   assign rsp_bus.body_length   = rsp_data.body_length;
   assign rsp_bus.last          = rsp_data.last;

   // A blocked output register must hold off input.
   `BCF_ASSERT_NEVER(a_no_overrun, clock, reset, rsp_bus.valid && !rsp_bus.ready && req_bus.ready, "input taken while output blocked")
   // Frame end always closes the burst; body bytes never do.
   `BCF_ASSERT_IMPL(a_end_last, clock, reset, rsp_bus.valid && rsp_bus.event_res == EV_END, rsp_bus.last, "frame end without last")
   `BCF_ASSERT_IMPL(a_byte_not_last, clock, reset, rsp_bus.valid && rsp_bus.event_res == EV_BYTE, !rsp_bus.last, "body byte flagged last")
   // Unknown-command errors carry cleared flags.
   `BCF_ASSERT_IMPL(a_unknown_flags, clock, reset, rsp_bus.valid && rsp_bus.event_res == EV_UNKNOWN, !rsp_bus.device_type && !rsp_bus.device_select, "unknown error with flags set")

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the bracketed command framer.
`timescale 1ns / 1ps

module testbench import bcf_pkg::*; ;

   localparam int FRAME_MAX     = 16;      // body capacity given to the dut
   localparam int TARGET_BEATS  = 380;     // beats the block acts on (idle drops excluded)
   localparam int CYCLE_LIMIT   = 400000;  // far beyond the slowest legal run
   localparam int SETTLE_CYCLES = 2 * FRAME_MAX + 8;  // longest playback plus margin
   localparam int N_DIRECTED    = 22;

   // Results whose value is obvious from the frame syntax alone.
   localparam bcf_rsp_type NO_RSP        = '0;
   localparam bcf_rsp_type UNKNOWN_RSP   = '{EV_UNKNOWN, 1'b0, 1'b0, 8'h00, 5'd0, 1'b1};
   localparam bcf_rsp_type EMPTY_END_RSP = '{EV_END, 1'b0, 1'b0, 8'h00, 5'd0, 1'b1};

   typedef enum logic [1:0] {FP_IDLE, FP_TYPE, FP_DEVICE, FP_BODY} frame_phase_type;

   typedef struct {
      logic [7:0]  rx;
      bit          typed;   // want holds the one result this beat must give
      bcf_rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   bcf_req_if req_bus ();
   bcf_rsp_if rsp_bus ();

   bracketed_command_framer #(
      .MAX_BODY (FRAME_MAX)
   ) dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Framing predictor: own copy of the parser state.
   // ------------------------------------------------------------------
   frame_phase_type fr_phase;
   logic         fr_type;
   logic         fr_dev;
   int           fr_count;
   logic [7:0]   fr_body [FRAME_MAX];
   bcf_rsp_type  frame_burst [FRAME_MAX + 1];   // results of the latest beat

   bcf_rsp_type  pending_results [$];           // expected, oldest first

   int  error_count    = 0;
   int  sent_beats     = 0;
   int  counted_beats  = 0;
   int  checked_beats  = 0;
   int  frames_ended   = 0;
   int  too_long_seen  = 0;
   int  unknown_seen   = 0;
   int  cycle_count    = 0;
   bit  tx_calm        = 1'b0;
   bit  rx_calm        = 1'b0;

   stim_row_type directed_rows [N_DIRECTED];

   // Advance the parser by one byte; fills frame_burst, returns the result count.
   function automatic int predict_framing(input logic [7:0] c);
      bcf_rsp_type r;
      int          n;
      int          i;
      r = '0;
      n = 0;
      case (fr_phase)
         FP_IDLE: begin
            if (c == CH_OPEN) fr_phase = FP_TYPE;
         end
         FP_TYPE: begin
            if (c == CH_F || c == CH_R) begin
               fr_type  = (c == CH_R);
               fr_phase = FP_DEVICE;
            end else begin
               // unknown command: flags read as zero
               fr_phase       = FP_IDLE;
               r.event_res    = EV_UNKNOWN;
               r.last         = 1'b1;
               frame_burst[0] = r;
               n              = 1;
            end
         end
         FP_DEVICE: begin
            if (c == CH_ONE || c == CH_H) begin
               fr_dev   = (c == CH_H);
               fr_count = 0;
               fr_phase = FP_BODY;
            end else begin
               fr_phase       = FP_IDLE;
               r.event_res    = EV_UNKNOWN;
               r.last         = 1'b1;
               frame_burst[0] = r;
               n              = 1;
            end
         end
         default: begin
            r.device_type   = fr_type;
            r.device_select = fr_dev;
            if (fr_count >= FRAME_MAX) begin
               // full body swallows any byte, brackets too
               fr_phase       = FP_IDLE;
               r.event_res    = EV_TOOLONG;
               r.last         = 1'b1;
               frame_burst[0] = r;
               n              = 1;
            end else if (c == CH_CLOSE) begin
               for (i = 0; i < fr_count; i++) begin
                  r.event_res    = EV_BYTE;
                  r.body_byte    = fr_body[i];
                  frame_burst[i] = r;
               end
               r.event_res           = EV_END;
               r.body_byte           = 8'h00;
               r.body_length         = fr_count[LEN_W-1:0];
               r.last                = 1'b1;
               frame_burst[fr_count] = r;
               n                     = fr_count + 1;
               fr_phase              = FP_IDLE;
            end else if (c == CH_OPEN) begin
               fr_phase = FP_TYPE;   // restart, body dropped
            end else begin
               fr_body[fr_count] = c;
               fr_count++;
            end
         end
      endcase
      return n;
   endfunction

   // ------------------------------------------------------------------
   // Input side
   // ------------------------------------------------------------------

   // Present one byte, wait for the beat, then book its expected results.
   task automatic send_byte(input logic [7:0] c, input bit typed = 1'b0,
                            input bcf_rsp_type want = '0);
      int gap;
      int n;
      int i;
      gap = tx_calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= c;
      do @(posedge clock); while (!req_bus.ready);
      sent_beats++;
      if (fr_phase != FP_IDLE || c == CH_OPEN) counted_beats++;
      n = predict_framing(c);
      if (typed) begin
         pending_results.push_back(want);
      end else begin
         for (i = 0; i < n; i++) pending_results.push_back(frame_burst[i]);
      end
   endtask

   // Sender holds off until the result side has caught up.
   task automatic drain_results();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_header();
      send_byte(CH_OPEN);
      send_byte($urandom_range(0, 1) ? CH_R : CH_F);
      send_byte($urandom_range(0, 1) ? CH_H : CH_ONE);
   endtask

   // Any byte except the brackets.
   function automatic logic [7:0] body_char();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CH_OPEN || c == CH_CLOSE);
      return c;
   endfunction

   function automatic logic [7:0] special_char();
      case ($urandom_range(0, 5))
         0:       return CH_OPEN;
         1:       return CH_CLOSE;
         2:       return CH_F;
         3:       return CH_R;
         4:       return CH_ONE;
         default: return CH_H;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Result side: random back-pressure, one draw per beat
   // ------------------------------------------------------------------
   initial begin
      int stall;
      int seen;
      seen          = 0;
      rsp_bus.ready = 1'b0;
      wait (!reset);
      forever begin
         if (seen % 20 == 0) rx_calm = ($urandom_range(0, 3) == 0);
         stall = rx_calm ? 0 : $urandom_range(0, 9);
         if (stall != 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid && rsp_bus.ready));
         seen++;
      end
   end

   task automatic check_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // Scoreboard: every accepted result beat against the oldest expectation.
   always @(posedge clock) begin
      bcf_rsp_type got;
      bcf_rsp_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.event_res     = rsp_bus.event_res;
         got.device_type   = rsp_bus.device_type;
         got.device_select = rsp_bus.device_select;
         got.body_byte     = rsp_bus.body_byte;
         got.body_length   = rsp_bus.body_length;
         got.last          = rsp_bus.last;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, got %h", $time, got);
            error_count++;
         end else begin
            want = pending_results.pop_front();
            checked_beats++;
            case (want.event_res)
               EV_END:     frames_ended++;
               EV_TOOLONG: too_long_seen++;
               EV_UNKNOWN: unknown_seen++;
               default: ;
            endcase
            check_field("event_res", int'(want.event_res), int'(got.event_res));
            check_field("device_type", int'(want.device_type), int'(got.device_type));
            check_field("device_select", int'(want.device_select),
                        int'(got.device_select));
            check_field("body_byte", int'(want.body_byte), int'(got.body_byte));
            check_field("body_length", int'(want.body_length), int'(got.body_length));
            check_field("last", int'(want.last), int'(got.last));
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: watchdog expired, %0d results still awaited",
                  $time, pending_results.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin
      int seq_count;
      int kind;
      int len;
      int i;
      logic [7:0] c;

      req_bus.valid   = 1'b0;
      req_bus.rx_byte = 8'h00;
      fr_phase        = FP_IDLE;
      fr_type         = 1'b0;
      fr_dev          = 1'b0;
      fr_count        = 0;
      seq_count       = 0;

      directed_rows = '{
         // idle drops: extremes and a stray close bracket
         '{8'h00,    1'b0, NO_RSP},
         '{8'hFF,    1'b0, NO_RSP},
         '{CH_CLOSE, 1'b0, NO_RSP},
         // bad type letter
         '{CH_OPEN,  1'b0, NO_RSP},
         '{8'h00,    1'b1, UNKNOWN_RSP},
         // good type, bad device letter
         '{CH_OPEN,  1'b0, NO_RSP},
         '{CH_R,     1'b0, NO_RSP},
         '{8'hFF,    1'b1, UNKNOWN_RSP},
         // empty body
         '{CH_OPEN,  1'b0, NO_RSP},
         '{CH_F,     1'b0, NO_RSP},
         '{CH_ONE,   1'b0, NO_RSP},
         '{CH_CLOSE, 1'b1, EMPTY_END_RSP},
         // body with extreme bytes, then restart on an open bracket
         '{CH_OPEN,  1'b0, NO_RSP},
         '{CH_R,     1'b0, NO_RSP},
         '{CH_H,     1'b0, NO_RSP},
         '{8'h00,    1'b0, NO_RSP},
         '{8'hFF,    1'b0, NO_RSP},
         '{CH_OPEN,  1'b0, NO_RSP},
         '{CH_F,     1'b0, NO_RSP},
         '{CH_H,     1'b0, NO_RSP},
         '{8'hA5,    1'b0, NO_RSP},
         '{CH_CLOSE, 1'b0, NO_RSP}
      };

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      for (i = 0; i < N_DIRECTED; i++)
         send_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].want);
      drain_results();

      // Random part: mostly well-formed frames with random content.
      while (counted_beats < TARGET_BEATS) begin
         if (seq_count % 24 == 0) tx_calm = ($urandom_range(0, 3) == 0);
         if (seq_count % 60 == 59) drain_results();
         seq_count++;
         kind = $urandom_range(0, 9);
         case (kind)
            6: begin
               // fill the body, then one more byte of any kind
               send_header();
               for (i = 0; i < FRAME_MAX; i++) send_byte(body_char());
               case ($urandom_range(0, 2))
                  0:       send_byte(CH_CLOSE);
                  1:       send_byte(CH_OPEN);
                  default: send_byte(8'($urandom_range(0, 255)));
               endcase
            end
            7: begin
               // restart mid-body, then a proper frame
               send_header();
               len = $urandom_range(0, 3);
               for (i = 0; i < len; i++) send_byte(body_char());
               send_byte(CH_OPEN);
               send_byte($urandom_range(0, 1) ? CH_R : CH_F);
               send_byte($urandom_range(0, 1) ? CH_H : CH_ONE);
               len = $urandom_range(0, 3);
               for (i = 0; i < len; i++) send_byte(body_char());
               send_byte(CH_CLOSE);
            end
            8: begin
               // broken header
               send_byte(CH_OPEN);
               send_byte($urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255)));
               if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
            end
            9: begin
               // line noise
               len = $urandom_range(1, 4);
               for (i = 0; i < len; i++) begin
                  c = $urandom_range(0, 1) ? special_char() : 8'($urandom_range(0, 255));
                  send_byte(c);
               end
            end
            default: begin
               // well-formed frame, short bodies mostly
               send_header();
               len = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 4)
                                                 : $urandom_range(5, FRAME_MAX);
               for (i = 0; i < len; i++) send_byte(body_char());
               send_byte(CH_CLOSE);
            end
         endcase
      end
      req_bus.valid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Sent %0d byte beats (%0d acted on), checked %0d result beats.",
               sent_beats, counted_beats, checked_beats);
      $display("Saw %0d frame ends, %0d too-long and %0d unknown-command errors.",
               frames_ended, too_long_seen, unknown_seen);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
